// File: rtl/dpg_pkg.sv
// Package of the docking path point generator: item types, register codes,
// fixed-point constants and the output saturation helper.
// Depends on nothing; used by docking_path_point_generator.
package dpg_pkg;

  typedef enum logic [1:0] {
    CFG_PATH_MODE   = 2'd0,
    CFG_POINT_COUNT = 2'd1,
    CFG_LOOKAHEAD   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic        [9:0]  point_index;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [15:0] goal_cos;
    logic signed [15:0] goal_sin;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] plain_x;
    logic signed [31:0] plain_y;
    logic               point_valid;
  } out_item_t;

  localparam int DIV_W = 44;
  localparam logic signed [17:0] K_FIFTH       = 18'sd13107;
  localparam logic signed [17:0] K_FOUR_FIFTHS = 18'sd52429;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/docking_path_point_generator.sv
// Top level of the docking path point generator: clamp and index decode,
// a restoring divider pipeline, control point rotation and de Casteljau stages.
// Depends on dpg_pkg.
//
//  channel | signals                                   | direction
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | write in
//  in      | in_valid_i in_ready_o in_item_i           | item in
//  out     | out_valid_o out_ready_i out_item_o        | item out
//
// One item enters per clock while the output is not stalled, and items leave in order.
// The divider resolves one quotient bit per stage.
// The whole pipeline advances together; when the output holds an item that is
// not taken, every stage freezes and the input is not ready.
// Reset clears the valid bits and loads the register defaults.
// Configuration writes are always taken.
module docking_path_point_generator #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dpg_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dpg_pkg::out_item_t out_item_o
);
  import dpg_pkg::*;

  localparam int CW  = 40;
  localparam int MW  = CW + 18;
  localparam int LW  = CW + 19;
  localparam int NST = DIV_W + 15;
  localparam int NTL = 12;
  localparam logic [16:0] MAXP = 17'(MAX_POINTS);

  typedef struct packed {
    logic               mode;
    logic               ok;
    logic               leg;
    logic               neg;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [15:0] c;
    logic signed [15:0] s;
  } ride_t;

  typedef struct packed {
    logic               mode;
    logic               ok;
    logic        [16:0] t;
    logic signed [45:0] lin_x;
    logic signed [45:0] lin_y;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [15:0] c;
    logic signed [15:0] s;
  } tail_t;

  logic               path_mode_q;
  logic [10:0]        point_count_q;
  logic signed [31:0] lookahead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_mode_q   <= 1'b1;
      point_count_q <= 11'd1000;
      lookahead_q   <= 32'sd6554;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PATH_MODE:   path_mode_q   <= cfg_data_i[0];
        CFG_POINT_COUNT: point_count_q <= cfg_data_i[10:0];
        CFG_LOOKAHEAD:   lookahead_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic [NST-1:0] vld_q;
  logic           en;

  assign en         = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // Decode of the index against the clamped count.
  ride_t              ride_c;
  logic [33:0]        mag_c;
  logic [9:0]         mult_c;
  logic [10:0]        dvs_c;

  always_comb begin
    logic [10:0]        n;
    logic [10:0]        nm1;
    logic [9:0]         h;
    logic [9:0]         hm1;
    logic [9:0]         idx;
    logic signed [33:0] span;
    if (point_count_q < 11'd3) begin
      n = 11'd3;
    end else if ({6'd0, point_count_q} > MAXP) begin
      n = MAXP[10:0];
    end else begin
      n = point_count_q;
    end
    nm1 = n - 11'd1;
    h   = n[10:1];
    hm1 = h - 10'd1;
    idx = in_item_i.point_index;
    ride_c.mode = path_mode_q;
    ride_c.gx   = in_item_i.goal_x;
    ride_c.gy   = in_item_i.goal_y;
    ride_c.sx   = in_item_i.start_x;
    ride_c.sy   = in_item_i.start_y;
    ride_c.c    = in_item_i.goal_cos;
    ride_c.s    = in_item_i.goal_sin;
    if (path_mode_q) begin
      ride_c.ok  = {1'b0, idx} <= nm1;
      ride_c.leg = 1'b0;
      span       = $signed({8'd0, idx, 16'd0});
      mult_c     = 10'd1;
      dvs_c      = nm1;
    end else begin
      ride_c.ok  = {1'b0, idx} <= ({h, 1'b0} - 11'd2);
      ride_c.leg = idx >= h;
      if (ride_c.leg) begin
        span   = 34'(in_item_i.goal_y) + 34'(lookahead_q) - 34'(in_item_i.start_y);
        mult_c = idx - hm1;
      end else begin
        span   = 34'(in_item_i.goal_x) - 34'(in_item_i.start_x);
        mult_c = idx;
      end
      dvs_c = (hm1 == 10'd0) ? 11'd1 : {1'b0, hm1};
    end
    ride_c.neg = span < 0;
    mag_c      = ride_c.neg ? 34'(-span) : 34'(span);
  end

  ride_t       s0_ride_q;
  logic [33:0] s0_mag_q;
  logic [9:0]  s0_mult_q;
  logic [10:0] s0_dvs_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_ride_q <= ride_c;
      s0_mag_q  <= mag_c;
      s0_mult_q <= mult_c;
      s0_dvs_q  <= dvs_c;
    end
  end

  logic [DIV_W-1:0] qn_q  [DIV_W+1];
  logic [10:0]      rem_q [DIV_W];
  logic [10:0]      dvs_q [DIV_W];
  ride_t            rd_q  [DIV_W+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      qn_q[0]  <= DIV_W'(s0_mag_q) * DIV_W'(s0_mult_q);
      rem_q[0] <= '0;
      dvs_q[0] <= s0_dvs_q;
      rd_q[0]  <= s0_ride_q;
    end
  end

  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    logic [11:0] trial;
    logic        ge;
    logic [11:0] diff;
    assign trial = {rem_q[k], qn_q[k][DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs_q[k]};
    assign diff  = trial - {1'b0, dvs_q[k]};
    always_ff @(posedge clk_i) begin
      if (en) begin
        qn_q[k+1] <= {qn_q[k][DIV_W-2:0], ge};
        rd_q[k+1] <= rd_q[k];
      end
    end
    if (k < DIV_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_q[k+1] <= ge ? diff[10:0] : trial[10:0];
          dvs_q[k+1] <= dvs_q[k];
        end
      end
    end
  end

  // Linear result and heading frame products.
  tail_t tail_c;

  always_comb begin
    logic signed [45:0] qs;
    ride_t              r;
    r  = rd_q[DIV_W];
    qs = $signed({2'b00, qn_q[DIV_W]});
    if (r.neg) begin
      qs = -qs;
    end
    tail_c.mode = r.mode;
    tail_c.ok   = r.ok;
    tail_c.t    = qn_q[DIV_W][16:0];
    tail_c.gx   = r.gx;
    tail_c.gy   = r.gy;
    tail_c.c    = r.c;
    tail_c.s    = r.s;
    tail_c.lin_x = r.leg ? 46'(r.gx) : 46'(r.sx) + qs;
    tail_c.lin_y = r.leg ? 46'(r.sy) + qs : 46'(r.sy);
  end

  tail_t tl_q [NTL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tl_q[0] <= tail_c;
      for (int i = 1; i < NTL; i++) begin
        tl_q[i] <= tl_q[i-1];
      end
    end
  end

  logic signed [47:0] g1_pcx_q, g1_psy_q, g1_pcy_q, g1_psx_q;
  logic signed [49:0] g1_pqx_q, g1_pqy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_pcx_q <= 48'(tail_c.c) * 48'(tail_c.gx);
      g1_psy_q <= 48'(tail_c.s) * 48'(tail_c.gy);
      g1_pcy_q <= 48'(tail_c.c) * 48'(tail_c.gy);
      g1_psx_q <= 48'(tail_c.s) * 48'(tail_c.gx);
      g1_pqx_q <= 50'(tail_c.gx) * 50'(K_FIFTH);
      g1_pqy_q <= 50'(tail_c.gy) * 50'(K_FOUR_FIFTHS);
    end
  end

  logic signed [CW-1:0] g2_x3r_q, g2_y3r_q, g2_qx1_q, g2_qy1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g2_x3r_q <= CW'((49'(g1_pcx_q) + 49'(g1_psy_q)) >>> 14);
      g2_y3r_q <= CW'((49'(g1_pcy_q) - 49'(g1_psx_q)) >>> 14);
      g2_qx1_q <= CW'(g1_pqx_q >>> 16);
      g2_qy1_q <= CW'(g1_pqy_q >>> 16);
    end
  end

  logic signed [MW-1:0] g3_k1_q, g3_k2_q;
  logic signed [MW-1:0] g3_r_q [8];
  logic signed [CW-1:0] g3_qx1_q, g3_qy1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g3_k1_q  <= MW'(g2_x3r_q) * MW'(K_FIFTH);
      g3_k2_q  <= MW'(g2_y3r_q) * MW'(K_FOUR_FIFTHS);
      g3_r_q[0] <= MW'(tl_q[1].c) * MW'(g2_x3r_q);
      g3_r_q[1] <= MW'(tl_q[1].s) * MW'(g2_y3r_q);
      g3_r_q[2] <= MW'(tl_q[1].s) * MW'(g2_x3r_q);
      g3_r_q[3] <= MW'(tl_q[1].c) * MW'(g2_y3r_q);
      g3_r_q[4] <= MW'(tl_q[1].c) * MW'(g2_x3r_q >>> 1);
      g3_r_q[5] <= MW'(tl_q[1].s) * MW'(g2_y3r_q);
      g3_r_q[6] <= MW'(tl_q[1].s) * MW'(g2_x3r_q >>> 1);
      g3_r_q[7] <= MW'(tl_q[1].c) * MW'(g2_y3r_q);
      g3_qx1_q <= g2_qx1_q;
      g3_qy1_q <= g2_qy1_q;
    end
  end

  logic signed [CW-1:0] g4_x3_q, g4_y3_q, g4_x2_q, g4_y2_q, g4_x1r_q, g4_y1r_q;
  logic signed [CW-1:0] g4_qx1_q, g4_qy1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g4_x3_q  <= CW'((g3_r_q[0] - g3_r_q[1]) >>> 14);
      g4_y3_q  <= CW'((g3_r_q[2] + g3_r_q[3]) >>> 14);
      g4_x2_q  <= CW'((g3_r_q[4] - g3_r_q[5]) >>> 14);
      g4_y2_q  <= CW'((g3_r_q[6] + g3_r_q[7]) >>> 14);
      g4_x1r_q <= CW'(g3_k1_q >>> 16);
      g4_y1r_q <= CW'(g3_k2_q >>> 16);
      g4_qx1_q <= g3_qx1_q;
      g4_qy1_q <= g3_qy1_q;
    end
  end

  logic signed [MW-1:0] g5_r_q [4];
  logic signed [CW-1:0] g5_x3_q, g5_y3_q, g5_x2_q, g5_y2_q, g5_qx1_q, g5_qy1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g5_r_q[0] <= MW'(tl_q[3].c) * MW'(g4_x1r_q);
      g5_r_q[1] <= MW'(tl_q[3].s) * MW'(g4_y1r_q);
      g5_r_q[2] <= MW'(tl_q[3].s) * MW'(g4_x1r_q);
      g5_r_q[3] <= MW'(tl_q[3].c) * MW'(g4_y1r_q);
      g5_x3_q   <= g4_x3_q;
      g5_y3_q   <= g4_y3_q;
      g5_x2_q   <= g4_x2_q;
      g5_y2_q   <= g4_y2_q;
      g5_qx1_q  <= g4_qx1_q;
      g5_qy1_q  <= g4_qy1_q;
    end
  end

  // Control points per lane: main x, main y, twin x, twin y.
  logic signed [CW-1:0] g6_pt_q [4][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      g6_pt_q[0][0] <= CW'((g5_r_q[0] - g5_r_q[1]) >>> 14);
      g6_pt_q[0][1] <= g5_x2_q;
      g6_pt_q[0][2] <= g5_x3_q;
      g6_pt_q[1][0] <= CW'((g5_r_q[2] + g5_r_q[3]) >>> 14);
      g6_pt_q[1][1] <= g5_y2_q;
      g6_pt_q[1][2] <= g5_y3_q;
      g6_pt_q[2][0] <= g5_qx1_q;
      g6_pt_q[2][1] <= CW'(tl_q[4].gx >>> 1);
      g6_pt_q[2][2] <= CW'(tl_q[4].gx);
      g6_pt_q[3][0] <= g5_qy1_q;
      g6_pt_q[3][1] <= CW'(tl_q[4].gy);
      g6_pt_q[3][2] <= CW'(tl_q[4].gy);
    end
  end

  logic signed [CW-1:0] l1b_q [4][3];
  logic signed [LW-1:0] l1m_q [4][3];
  logic signed [CW-1:0] l1p_q [4][3];
  logic signed [CW-1:0] l2b_q [4][2];
  logic signed [LW-1:0] l2m_q [4][2];
  logic signed [CW-1:0] l2p_q [4][2];
  logic signed [CW-1:0] l3b_q [4];
  logic signed [LW-1:0] l3m_q [4];
  logic signed [CW-1:0] l3p_q [4];
  logic signed [LW-1:0] t6_s, t8_s, t10_s;

  assign t6_s  = LW'($signed({1'b0, tl_q[5].t}));
  assign t8_s  = LW'($signed({1'b0, tl_q[7].t}));
  assign t10_s = LW'($signed({1'b0, tl_q[9].t}));

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        l1b_q[l][0] <= '0;
        l1m_q[l][0] <= LW'(g6_pt_q[l][0]) * t6_s;
        for (int j = 1; j < 3; j++) begin
          l1b_q[l][j] <= g6_pt_q[l][j-1];
          l1m_q[l][j] <= (LW'(g6_pt_q[l][j]) - LW'(g6_pt_q[l][j-1])) * t6_s;
        end
        for (int j = 0; j < 3; j++) begin
          l1p_q[l][j] <= l1b_q[l][j] + CW'(l1m_q[l][j] >>> 16);
        end
        for (int j = 0; j < 2; j++) begin
          l2b_q[l][j] <= l1p_q[l][j];
          l2m_q[l][j] <= (LW'(l1p_q[l][j+1]) - LW'(l1p_q[l][j])) * t8_s;
          l2p_q[l][j] <= l2b_q[l][j] + CW'(l2m_q[l][j] >>> 16);
        end
        l3b_q[l] <= l2p_q[l][0];
        l3m_q[l] <= (LW'(l2p_q[l][1]) - LW'(l2p_q[l][0])) * t10_s;
        l3p_q[l] <= l3b_q[l] + CW'(l3m_q[l] >>> 16);
      end
    end
  end

  out_item_t out_d, out_q;

  always_comb begin
    tail_t tl;
    tl    = tl_q[NTL-1];
    out_d = '0;
    if (tl.ok) begin
      out_d.point_valid = 1'b1;
      if (tl.mode) begin
        out_d.point_x = sat32(48'(l3p_q[0]));
        out_d.point_y = sat32(48'(l3p_q[1]));
        out_d.plain_x = sat32(48'(l3p_q[2]));
        out_d.plain_y = sat32(48'(l3p_q[3]));
      end else begin
        out_d.point_x = sat32(48'(tl.lin_x));
        out_d.point_y = sat32(48'(tl.lin_y));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[NST-1];
  assign out_item_o  = out_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.point_valid |->
      out_item_o.point_x == 0 && out_item_o.point_y == 0 &&
      out_item_o.plain_x == 0 && out_item_o.plain_y == 0)
    else $error("invalid point carries nonzero coordinates");

  a_linear_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !path_mode_q |-> out_item_o.plain_x == 0 && out_item_o.plain_y == 0)
    else $error("twin curve output in linear mode");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(vld_q))
    else $error("pipeline moved while output stalled");

endmodule
